### src/sdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_pkg
// shared types and constants of the subtree dirty mark unit
// ----------------------------------------------------------------------------
package sdm_pkg;

	localparam int NUM_NODES = 1024;
	localparam int WL_DEPTH  = 512;

	localparam int NODE_W = 10;
	localparam int CNT_W  = 10;
	localparam int SUM_W  = NODE_W + 1;
	localparam int WL_AW  = $clog2(WL_DEPTH);
	localparam int FILL_W = $clog2(WL_DEPTH + 1);
	localparam int NEW_W  = 11;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_MARK  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [NODE_W-1:0] wdata;
	} wl_req_t;

	typedef struct packed {
		logic [NODE_W-1:0] rdata;
		logic [FILL_W-1:0] fill;
	} wl_rsp_t;

	typedef struct packed {
		logic [NODE_W-1:0] addr;
		logic              tbl_we;
		logic [NODE_W-1:0] first;
		logic [CNT_W-1:0]  count;
		logic              mk_we;
		logic              mk_wdata;
	} nm_req_t;

	typedef struct packed {
		logic [NODE_W-1:0] first;
		logic [CNT_W-1:0]  count;
		logic              mark;
	} nm_rsp_t;

	typedef struct packed {
		status_t          status;
		logic [NEW_W-1:0] newly_marked;
		logic             mark_value;
	} result_t;

endpackage

### src/sdm_worklist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_worklist
// last-in first-out node stack with fill count and registered pop data
// ----------------------------------------------------------------------------
module sdm_worklist (
	input  logic            clk,
	input  logic            arst_n,
	input  sdm_pkg::wl_req_t req,
	output sdm_pkg::wl_rsp_t rsp
);

	logic [sdm_pkg::NODE_W-1:0] mem [sdm_pkg::WL_DEPTH];
	logic [sdm_pkg::FILL_W-1:0] fill_q;
	logic [sdm_pkg::NODE_W-1:0] rdata_q;
	logic [sdm_pkg::FILL_W-1:0] top_idx;

	assign top_idx = fill_q - sdm_pkg::FILL_W'(1);

	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[fill_q[sdm_pkg::WL_AW-1:0]] <= req.wdata;
		end
		if (req.pop) begin
			rdata_q <= mem[top_idx[sdm_pkg::WL_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (req.push) begin
			fill_q <= fill_q + sdm_pkg::FILL_W'(1);
		end else if (req.pop) begin
			fill_q <= top_idx;
		end
	end

	assign rsp.rdata = rdata_q;
	assign rsp.fill  = fill_q;

endmodule

### src/sdm_nodemem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_nodemem
// hierarchy table and dirty mark memories, one shared address, registered read
// ----------------------------------------------------------------------------
module sdm_nodemem (
	input  logic            clk,
	input  sdm_pkg::nm_req_t req,
	output sdm_pkg::nm_rsp_t rsp
);

	logic [sdm_pkg::NODE_W+sdm_pkg::CNT_W-1:0] tbl_mem [sdm_pkg::NUM_NODES];
	logic                                      mk_mem  [sdm_pkg::NUM_NODES];
	logic [sdm_pkg::NODE_W+sdm_pkg::CNT_W-1:0] tbl_rd_q;
	logic                                      mk_rd_q;

	always_ff @(posedge clk) begin
		if (req.tbl_we) begin
			tbl_mem[req.addr] <= {req.first, req.count};
		end
		tbl_rd_q <= tbl_mem[req.addr];
	end

	always_ff @(posedge clk) begin
		if (req.mk_we) begin
			mk_mem[req.addr] <= req.mk_wdata;
		end
		mk_rd_q <= mk_mem[req.addr];
	end

	assign rsp.first = tbl_rd_q[sdm_pkg::NODE_W+sdm_pkg::CNT_W-1:sdm_pkg::CNT_W];
	assign rsp.count = tbl_rd_q[sdm_pkg::CNT_W-1:0];
	assign rsp.mark  = mk_rd_q;

endmodule

### src/sdm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_ctrl
// command sequencer: clearing sweep, table load, mark read and subtree walk
// ----------------------------------------------------------------------------
module sdm_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  sdm_pkg::cmd_t              in_cmd,
	input  logic [sdm_pkg::NODE_W-1:0] in_idx,
	input  logic [sdm_pkg::NODE_W-1:0] in_first,
	input  logic [sdm_pkg::CNT_W-1:0]  in_count,
	output sdm_pkg::nm_req_t           nm_req,
	input  sdm_pkg::nm_rsp_t           nm_rsp,
	output sdm_pkg::wl_req_t           wl_req,
	input  sdm_pkg::wl_rsp_t           wl_rsp,
	input  logic                       out_free,
	output logic                       res_valid,
	output sdm_pkg::result_t           res
);

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_PUSH,
		S_NODE,
		S_DONE
	} state_t;

	localparam int SW = sdm_pkg::SUM_W;

	state_t                     state_q;
	logic [sdm_pkg::NODE_W-1:0] sweep_q;
	logic                       clr_res_q;
	logic [sdm_pkg::NODE_W-1:0] node_q;
	logic [sdm_pkg::NODE_W-1:0] child_q;
	logic [sdm_pkg::CNT_W-1:0]  remain_q;
	sdm_pkg::result_t           res_q;

	logic                       idx_ok;
	logic                       wl_nonempty;
	logic                       push_go;
	logic                       ovf_hit;
	logic                       rng_hit;
	logic [SW-1:0]              room;
	logic [sdm_pkg::CNT_W-1:0]  push_cnt;

	assign idx_ok      = SW'(in_idx) < SW'(sdm_pkg::NUM_NODES);
	assign wl_nonempty = wl_rsp.fill != '0;
	assign push_go     = (remain_q != '0) &&
		(wl_rsp.fill < sdm_pkg::FILL_W'(sdm_pkg::WL_DEPTH));

	// children past the last node sit at the tail of the run
	assign ovf_hit  = (SW'(wl_rsp.fill) + SW'(nm_rsp.count)) >= SW'(sdm_pkg::WL_DEPTH);
	assign rng_hit  = (SW'(nm_rsp.first) + SW'(nm_rsp.count)) > SW'(sdm_pkg::NUM_NODES);
	assign room     = SW'(sdm_pkg::NUM_NODES) - SW'(nm_rsp.first);
	assign push_cnt = (SW'(nm_rsp.count) <= room) ? nm_rsp.count : room[sdm_pkg::CNT_W-1:0];

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = (state_q == S_DONE) && out_free;
	assign res       = res_q;

	always_comb begin
		nm_req          = '0;
		nm_req.addr     = node_q;
		nm_req.first    = in_first;
		nm_req.count    = in_count;
		wl_req          = '0;
		wl_req.wdata    = child_q;
		case (state_q)
			S_IDLE: begin
				nm_req.addr = in_idx;
				if (in_valid && idx_ok && in_cmd == sdm_pkg::CMD_LOAD) begin
					nm_req.tbl_we = 1'b1;
				end
			end
			S_SWEEP: begin
				nm_req.addr     = sweep_q;
				nm_req.mk_we    = 1'b1;
				nm_req.mk_wdata = 1'b0;
			end
			S_NODE: begin
				nm_req.addr = wl_rsp.rdata;
			end
			S_CHECK: begin
				if (!nm_rsp.mark) begin
					nm_req.mk_we    = 1'b1;
					nm_req.mk_wdata = 1'b1;
				end else if (wl_nonempty) begin
					wl_req.pop = 1'b1;
				end
			end
			S_PUSH: begin
				if (push_go) begin
					wl_req.push = 1'b1;
				end else if (wl_nonempty) begin
					wl_req.pop = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			sweep_q   <= '0;
			clr_res_q <= 1'b0;
			node_q    <= '0;
			child_q   <= '0;
			remain_q  <= '0;
			res_q     <= '{status: sdm_pkg::ST_OK, newly_marked: '0, mark_value: 1'b0};
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						node_q <= in_idx;
						if (in_cmd == sdm_pkg::CMD_CLEAR) begin
							res_q     <= '{status: sdm_pkg::ST_OK, newly_marked: '0,
								mark_value: 1'b0};
							sweep_q   <= '0;
							clr_res_q <= 1'b1;
							state_q   <= S_SWEEP;
						end else if (!idx_ok) begin
							res_q   <= '{status: sdm_pkg::ST_RANGE, newly_marked: '0,
								mark_value: 1'b0};
							state_q <= S_DONE;
						end else begin
							res_q <= '{status: sdm_pkg::ST_OK, newly_marked: '0,
								mark_value: 1'b0};
							case (in_cmd)
								sdm_pkg::CMD_MARK: state_q <= S_CHECK;
								sdm_pkg::CMD_READ: state_q <= S_READ;
								default:           state_q <= S_DONE;
							endcase
						end
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + sdm_pkg::NODE_W'(1);
					if (sweep_q == sdm_pkg::NODE_W'(sdm_pkg::NUM_NODES - 1)) begin
						clr_res_q <= 1'b0;
						state_q   <= clr_res_q ? S_DONE : S_IDLE;
					end
				end
				S_READ: begin
					res_q.mark_value <= nm_rsp.mark;
					state_q          <= S_DONE;
				end
				S_CHECK: begin
					if (nm_rsp.mark) begin
						state_q <= wl_nonempty ? S_NODE : S_DONE;
					end else begin
						res_q.newly_marked <= res_q.newly_marked + sdm_pkg::NEW_W'(1);
						if (ovf_hit) begin
							res_q.status <= sdm_pkg::ST_OVERFLOW;
						end else if (rng_hit && res_q.status != sdm_pkg::ST_OVERFLOW) begin
							res_q.status <= sdm_pkg::ST_RANGE;
						end
						child_q  <= nm_rsp.first;
						remain_q <= push_cnt;
						state_q  <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (push_go) begin
						child_q  <= child_q + sdm_pkg::NODE_W'(1);
						remain_q <= remain_q - sdm_pkg::CNT_W'(1);
					end else begin
						state_q <= wl_nonempty ? S_NODE : S_DONE;
					end
				end
				S_NODE: begin
					node_q  <= wl_rsp.rdata;
					state_q <= S_CHECK;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/subtree_dirty_mark_grouped_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtree_dirty_mark_grouped_unit
// hierarchy table with per-node dirty marks and a worklist subtree marker
// ----------------------------------------------------------------------------
// One command at a time. Clear sweeps every node of the mark memory, and a
// mark command walks the subtree through a stack memory whose single port
// takes one push or pop a cycle. After reset the same clearing pass runs
// before the first item is accepted. A finished result sits in an output
// register, so the next item can be taken while it waits.
// ----------------------------------------------------------------------------
module subtree_dirty_mark_grouped_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // node_index, first_child, child_count, zero pad
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // mark_value, newly_marked, status, zero pad
);

	sdm_pkg::nm_req_t nm_req;
	sdm_pkg::nm_rsp_t nm_rsp;
	sdm_pkg::wl_req_t wl_req;
	sdm_pkg::wl_rsp_t wl_rsp;
	sdm_pkg::result_t res;
	sdm_pkg::result_t out_q;
	logic             res_valid;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;

	sdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (sdm_pkg::cmd_t'(s_tuser)),
		.in_idx    (s_tdata[9:0]),
		.in_first  (s_tdata[19:10]),
		.in_count  (s_tdata[29:20]),
		.nm_req    (nm_req),
		.nm_rsp    (nm_rsp),
		.wl_req    (wl_req),
		.wl_rsp    (wl_rsp),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	sdm_nodemem u_nodemem (
		.clk (clk),
		.req (nm_req),
		.rsp (nm_rsp)
	);

	sdm_worklist u_worklist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (wl_req),
		.rsp    (wl_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.status, out_q.newly_marked, out_q.mark_value};

endmodule

### src/sdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_checker
// port-level checks of the subtree dirty mark unit
// ----------------------------------------------------------------------------
module sdm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// an accepted command takes the sequencer out of idle, so input is not ready right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:12] != 2'd3)
		else $error("unknown status code");

	// a set mark only comes from a read, which never counts nodes
	a_read_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[11:1] == 11'd0 && m_tdata[13:12] == 2'd0)
		else $error("read result carries a count or fault");

endmodule

bind subtree_dirty_mark_grouped_unit sdm_checker u_sdm_checker (.*);
